// ===== design/lwkd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lwkd_pkg;

   localparam int SYMBOL_W    = 8;
   localparam int NUM_SYMBOLS = 256;
   localparam int DISTINCT_W  = 9;
   localparam int BEST_W      = 13;

   localparam logic [DISTINCT_W-1:0] DISTINCT_RESET = 9'd1;

   typedef struct packed {
      logic [BEST_W-1:0] best_length;
      logic              string_done;
      logic              overflow;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/lwkd_count_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lwkd_count_ram
   import lwkd_pkg::*;
#(
   parameter int DATA_W = 13
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire logic [SYMBOL_W-1:0] rd_addr,
   output logic      [DATA_W-1:0]   rd_data,
   input  wire logic                wr_en,
   input  wire logic [SYMBOL_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]   wr_data
);

   logic [DATA_W-1:0]      mem [NUM_SYMBOLS];
   logic [DATA_W-1:0]      mem_q_ff;
   logic [SYMBOL_W-1:0]    rd_addr_ff;
   logic [NUM_SYMBOLS-1:0] valid_ff;
   logic [NUM_SYMBOLS-1:0] valid_in;
   logic                   byp_hit_ff;
   logic                   byp_hit_in;
   logic [DATA_W-1:0]      byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff    <= mem[rd_addr];
      rd_addr_ff  <= rd_addr;
      byp_data_ff <= wr_data;
   end

   // valid bits stand in for clearing the table between strings
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      byp_hit_in = wr_en && !clear && (wr_addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         byp_hit_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         byp_hit_ff <= byp_hit_in;
      end
   end

   assign rd_data = byp_hit_ff           ? byp_data_ff :
                    valid_ff[rd_addr_ff] ? mem_q_ff    : '0;

endmodule
`default_nettype wire

// ===== design/lwkd_window_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lwkd_window_ram
   import lwkd_pkg::*;
#(
   parameter  int DEPTH  = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire logic [SYMBOL_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output logic      [SYMBOL_W-1:0] rd_data
);

   logic [SYMBOL_W-1:0] mem [DEPTH];
   logic [SYMBOL_W-1:0] mem_q_ff;
   logic [SYMBOL_W-1:0] byp_data_ff;
   logic                byp_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff    <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   // read of the entry being written in the same cycle returns the new byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else begin
         byp_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : mem_q_ff;

endmodule
`default_nettype wire

// ===== design/lwkd_rsp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lwkd_rsp_queue
   import lwkd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rsp_type      out_data,
   output logic [1:0]   level
);

   logic    head_valid_ff;
   logic    head_valid_in;
   logic    tail_valid_ff;
   logic    tail_valid_in;
   rsp_type head_data_ff;
   rsp_type head_data_in;
   rsp_type tail_data_ff;
   rsp_type tail_data_in;
   logic    pop;

   assign pop = head_valid_ff && !out_stall;

   always_comb begin
      if (pop) begin
         head_valid_in = tail_valid_ff;
         head_data_in  = tail_data_ff;
         tail_valid_in = 1'b0;
      end else begin
         head_valid_in = head_valid_ff;
         head_data_in  = head_data_ff;
         tail_valid_in = tail_valid_ff;
      end
      tail_data_in = tail_data_ff;
      if (push) begin
         if (!head_valid_in) begin
            head_valid_in = 1'b1;
            head_data_in  = push_data;
         end else begin
            tail_valid_in = 1'b1;
            tail_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
      head_data_ff <= head_data_in;
      tail_data_ff <= tail_data_in;
   end

   assign out_valid = head_valid_ff;
   assign out_data  = head_data_ff;
   assign level     = {1'b0, head_valid_ff} + {1'b0, tail_valid_ff};

endmodule
`default_nettype wire

// ===== design/longest_window_k_distinct_symbols_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Longest window with exactly K distinct byte symbols, non-shrinking sliding window.
// A string streams in one byte per transfer, its final byte marked; one result follows
// every byte, carrying the best window length so far, the end-of-string mark and a
// sticky overflow flag set once a window needed more than MAX_WINDOW buffered bytes.
// The user writes K (reset value 1) on the csr channel only while the block is idle;
// the block does not enforce this. A byte is taken only once the prior byte left stage
// 0 and the queue has room; per byte the 256-entry count table, on one read port and
// one write port, is read and written twice (the new symbol, then the symbol leaving
// the window). A two-entry result queue lets input flow while results wait. Counts are
// cleared by per-symbol valid bits at reset and after a final byte, no clearing pass.
module longest_window_k_distinct_symbols_core
   import lwkd_pkg::*;
#(
   parameter int MAX_WINDOW = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [DISTINCT_W-1:0] csr_distinct_target,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [SYMBOL_W-1:0]   req_symbol,
   input  wire logic                  req_last_symbol,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [BEST_W-1:0]     rsp_best_length,
   output logic                       rsp_string_done,
   output logic                       rsp_overflow
);

   localparam int POS_W = $clog2(MAX_WINDOW);
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_WINDOW);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_WINDOW - 1);

   function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos);
      advance = (pos == LAST_POS) ? '0 : pos + 1'b1;
   endfunction

   // configuration
   logic [DISTINCT_W-1:0] target_ff;

   // string state
   logic [POS_W-1:0]      wp_ff,       wp_in;
   logic [POS_W-1:0]      left_ff,     left_in;
   logic [LEN_W-1:0]      wlen_ff,     wlen_in;
   logic [DISTINCT_W-1:0] distinct_ff, distinct_in;
   logic [LEN_W-1:0]      best_ff,     best_in;
   logic                  ovf_ff,      ovf_in;

   // stage 0: read count of new symbol, write and read window buffer
   logic                  s0_valid_ff;
   logic [SYMBOL_W-1:0]   s0_symbol_ff;
   logic                  s0_last_ff;
   // stage 1: update count of new symbol, read count of leaving symbol
   logic                  s1_valid_ff;
   logic [SYMBOL_W-1:0]   s1_symbol_ff;
   logic                  s1_last_ff;
   logic [POS_W-1:0]      s1_left_ff;
   logic [LEN_W-1:0]      s1_wlen_ff;
   // stage 2: decrement count of leaving symbol
   logic                  s2_valid_ff;
   logic                  s2_last_ff;
   logic                  s2_evict_ff;
   logic [SYMBOL_W-1:0]   s2_old_ff;
   logic [DISTINCT_W-1:0] s2_distinct_ff;

   logic                  accept;
   logic [1:0]            queue_level;
   logic                  full_step;
   logic [POS_W-1:0]      left_eff;
   logic [LEN_W-1:0]      wlen_eff;

   logic [SYMBOL_W-1:0]   old_symbol;
   logic [LEN_W-1:0]      cnt_rd_data;
   logic [SYMBOL_W-1:0]   cnt_rd_addr;
   logic                  cnt_wr_en;
   logic [SYMBOL_W-1:0]   cnt_wr_addr;
   logic [LEN_W-1:0]      cnt_wr_data;
   logic                  cnt_clear;

   logic [LEN_W-1:0]      cnt_new;
   logic [DISTINCT_W-1:0] distinct_step;
   logic                  match;
   logic                  evict;
   logic [LEN_W-1:0]      best_step;
   logic                  dec;
   logic                  drop;
   rsp_type               push_data;
   rsp_type               out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= DISTINCT_RESET;
      end else if (csr_valid && csr_ready) begin
         target_ff <= csr_distinct_target;
      end
   end

   // one byte in stage 0 at a time, and room kept in the result queue
   assign req_stall = s0_valid_ff ||
                      ((3'(queue_level) + 3'(s1_valid_ff)) >= 3'd2);
   assign accept    = req_valid && !req_stall;

   // stage 0 address math
   assign full_step = (wlen_ff == MAX_LEN);
   assign left_eff  = full_step ? advance(left_ff) : left_ff;
   assign wlen_eff  = full_step ? MAX_LEN : wlen_ff + 1'b1;

   lwkd_window_ram #(
      .DEPTH (MAX_WINDOW)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s0_valid_ff),
      .wr_addr (wp_ff),
      .wr_data (s0_symbol_ff),
      .rd_addr (left_eff),
      .rd_data (old_symbol)
   );

   // stage 1 and stage 2 arithmetic
   always_comb begin
      cnt_new       = (cnt_rd_data < MAX_LEN) ? cnt_rd_data + 1'b1 : cnt_rd_data;
      distinct_step = distinct_ff + DISTINCT_W'(cnt_rd_data == '0);
      match         = (distinct_step == target_ff);
      evict         = (distinct_step > target_ff);
      best_step     = (match && (s1_wlen_ff > best_ff)) ? s1_wlen_ff : best_ff;
      dec           = s2_evict_ff && (cnt_rd_data != '0);
      drop          = dec && (cnt_rd_data == LEN_W'(1));
   end

   // count table port steering: stages 0 and 1 never overlap, nor do 1 and 2
   always_comb begin
      cnt_rd_addr = s1_valid_ff ? old_symbol : s0_symbol_ff;
      if (s1_valid_ff) begin
         cnt_wr_en   = 1'b1;
         cnt_wr_addr = s1_symbol_ff;
         cnt_wr_data = cnt_new;
      end else begin
         cnt_wr_en   = s2_valid_ff && dec && !s2_last_ff;
         cnt_wr_addr = s2_old_ff;
         cnt_wr_data = cnt_rd_data - 1'b1;
      end
      cnt_clear = s2_valid_ff && s2_last_ff;
   end

   lwkd_count_ram #(
      .DATA_W (LEN_W)
   ) u_counts (
      .clock   (clock),
      .reset   (reset),
      .clear   (cnt_clear),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data)
   );

   // string state next values
   always_comb begin
      wp_in       = wp_ff;
      left_in     = left_ff;
      wlen_in     = wlen_ff;
      distinct_in = distinct_ff;
      best_in     = best_ff;
      ovf_in      = ovf_ff;
      if (s0_valid_ff) begin
         wp_in  = advance(wp_ff);
         ovf_in = ovf_ff || full_step;
      end
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            wp_in   = '0;
            left_in = '0;
            wlen_in = '0;
            best_in = '0;
         end else begin
            left_in = evict ? advance(s1_left_ff) : s1_left_ff;
            wlen_in = evict ? s1_wlen_ff - 1'b1 : s1_wlen_ff;
            best_in = best_step;
         end
      end
      if (s2_valid_ff) begin
         distinct_in = s2_last_ff ? '0 : s2_distinct_ff - DISTINCT_W'(drop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         left_ff     <= '0;
         wlen_ff     <= '0;
         distinct_ff <= '0;
         best_ff     <= '0;
         ovf_ff      <= 1'b0;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         left_ff     <= left_in;
         wlen_ff     <= wlen_in;
         distinct_ff <= distinct_in;
         best_ff     <= best_in;
         ovf_ff      <= ovf_in;
         s0_valid_ff <= accept;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_symbol_ff <= req_symbol;
         s0_last_ff   <= req_last_symbol;
      end
      s1_symbol_ff   <= s0_symbol_ff;
      s1_last_ff     <= s0_last_ff;
      s1_left_ff     <= left_eff;
      s1_wlen_ff     <= wlen_eff;
      s2_last_ff     <= s1_last_ff;
      s2_evict_ff    <= evict;
      s2_old_ff      <= old_symbol;
      s2_distinct_ff <= distinct_step;
   end

   // result leaves stage 1; the eviction tail does not change it
   always_comb begin
      push_data.best_length = BEST_W'(best_step);
      push_data.string_done = s1_last_ff;
      push_data.overflow    = ovf_ff;
   end

   lwkd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (push_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data),
      .level     (queue_level)
   );

   assign rsp_best_length = out_data.best_length;
   assign rsp_string_done = out_data.string_done;
   assign rsp_overflow    = out_data.overflow;

endmodule
`default_nettype wire
